// ----- hdl/meu_pkg.sv -----
// Package for the modular exponentiation unit: operation codes.
// Used by modular_exponentiation_unit_top; depends on nothing.
`default_nettype none
package meu_pkg;
  localparam logic [1:0] ActPower   = 2'd0;
  localparam logic [1:0] ActInverse = 2'd1;
  localparam logic [1:0] ActProduct = 2'd2;
endpackage
`default_nettype wire

// ----- hdl/modular_exponentiation_unit_top.sv -----
// Modular exponentiation unit: square-and-multiply over a shared shift-and-add
// modular multiplier. Depends on meu_pkg for the operation codes.
// Sequence: one reduction pass over the base, then a chain of modular
// multiplications (a single one for a product); the unused code goes straight to
// the done state and returns zero. Busy is low again in the strobe cycle, so a
// new operation can be accepted in the strobe cycle.
// The result strobe lasts one cycle and cannot be stalled. Reset sets the modulus to 1.
`default_nettype none
module modular_exponentiation_unit_top #(
  parameter int WORD_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action_i,
  input  wire logic [63:0] operand_a_i,
  input  wire logic [63:0] operand_b_i,
  output logic             done,
  output logic [63:0]      residue_o
);
  localparam int CntW = $clog2(WORD_BITS);
  localparam int W = WORD_BITS;

  typedef enum logic [2:0] {
    StIdle, StReduce, StMulAcc, StMulSq, StDone
  } state_e;

  state_e          state_q;
  logic [63:0]     modulus_q;
  logic [W-1:0]    m_q, base_q, acc_q, exp_q, r_q, mx_q, my_q;
  logic [CntW-1:0] cnt_q;
  logic            prod_q;

  // Effective modulus, zero read as one.
  logic [W-1:0] m_eff;
  always_comb begin
    m_eff = modulus_q[W-1:0];
    if (m_eff == '0) m_eff = {{(W-1){1'b0}}, 1'b1};
  end

  // Shared step: r = 2r (+ x) mod m, with x < m, r < m.
  logic [W:0]   dbl, add_s;
  logic [W-1:0] dbl_r, step_r;
  logic [W-1:0] red_r;
  always_comb begin
    dbl   = {r_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : dbl[W-1:0];
    add_s = {1'b0, dbl_r} + {1'b0, mx_q};
    step_r = (my_q[W-1] && (add_s >= {1'b0, m_q})) ? W'(add_s - {1'b0, m_q}) :
             (my_q[W-1] ? add_s[W-1:0] : dbl_r);
    // Reduction of the raw base is a multiplication by one, with mx=1 mod m and my=base:
    // done as binary long reduction, bit by bit from the top of the base.
    red_r = step_r;
  end

  logic last;
  assign last = (cnt_q == CntW'(W-1));
  assign busy = (state_q != StIdle);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= 64'd1;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      done      <= 1'b0;
      residue_o <= '0;
      cnt_q     <= '0;
      prod_q    <= 1'b0;
      m_q       <= '0;
      base_q    <= '0;
      acc_q     <= '0;
      exp_q     <= '0;
      r_q       <= '0;
      mx_q      <= '0;
      my_q      <= '0;
    end else begin
      done <= (state_q == StDone);
      unique case (state_q)
        StIdle: begin
          if (start) begin
            m_q    <= m_eff;
            r_q    <= '0;
            cnt_q  <= '0;
            // Reduce the base: multiply A by one using A's bits as the multiplier.
            mx_q   <= {{(W-1){1'b0}}, (m_eff != {{(W-1){1'b0}}, 1'b1})};
            my_q   <= operand_a_i[W-1:0];
            base_q <= operand_a_i[W-1:0];
            prod_q <= (action_i == meu_pkg::ActProduct);
            exp_q  <= (action_i == meu_pkg::ActInverse) ? W'(m_eff - W'(2)) :
                      operand_b_i[W-1:0];
            if (action_i == meu_pkg::ActPower || action_i == meu_pkg::ActInverse ||
                action_i == meu_pkg::ActProduct) begin
              acc_q   <= {{(W-1){1'b0}}, 1'b1};
              state_q <= StReduce;
            end else begin
              acc_q   <= '0;
              state_q <= StDone;
            end
          end
        end
        StReduce: begin
          if (last) begin
            cnt_q  <= '0;
            r_q    <= '0;
            base_q <= red_r;
            if (prod_q) begin
              mx_q    <= red_r;
              my_q    <= exp_q;
              acc_q   <= '0;
              exp_q   <= {{(W-1){1'b0}}, 1'b1};
              state_q <= StMulAcc;
            end else if (exp_q == '0) begin
              state_q <= StDone;
            end else begin
              mx_q    <= red_r;
              my_q    <= exp_q[0] ? acc_q : red_r;
              state_q <= exp_q[0] ? StMulAcc : StMulSq;
            end
          end else begin
            r_q   <= red_r;
            my_q  <= {my_q[W-2:0], 1'b0};
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StMulAcc: begin
          if (last) begin
            cnt_q <= '0;
            r_q   <= '0;
            acc_q <= step_r;
            if (prod_q || exp_q == {{(W-1){1'b0}}, 1'b1}) begin
              state_q <= StDone;
            end else begin
              mx_q    <= base_q;
              my_q    <= base_q;
              state_q <= StMulSq;
            end
          end else begin
            r_q   <= step_r;
            my_q  <= {my_q[W-2:0], 1'b0};
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StMulSq: begin
          if (last) begin
            cnt_q  <= '0;
            r_q    <= '0;
            base_q <= step_r;
            exp_q  <= exp_q >> 1;
            mx_q   <= step_r;
            if (exp_q[1]) begin
              my_q    <= acc_q;
              state_q <= StMulAcc;
            end else begin
              my_q    <= step_r;
            end
          end else begin
            r_q   <= step_r;
            my_q  <= {my_q[W-2:0], 1'b0};
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StDone: begin
          residue_o <= 64'(acc_q);
          state_q   <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Checks on the sequencer.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> (done && !busy)) else $error("result not delivered");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item not taken");
endmodule
`default_nettype wire
